// ===== src/eerm_pkg.sv =====
// ----------------------------------------------------------------------------
// eerm_pkg
// Shared types and constants for the echo error rate monitor.
// ----------------------------------------------------------------------------
package eerm_pkg;

  // Field widths
  localparam int unsigned EchoW    = 10;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DistW    = 14;
  localparam int unsigned StreakW  = 16;
  localparam int unsigned CountW   = 7;
  localparam int unsigned PercentW = 7;
  localparam int unsigned CfgIdxW  = 2;

  // Stream packing
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

  localparam int unsigned InEchoLsb = 0;
  localparam int unsigned InTimeLsb = InEchoLsb + EchoW;

  localparam int unsigned OutDistLsb  = 0;
  localparam int unsigned OutInrBit   = OutDistLsb + DistW;
  localparam int unsigned OutTrkBit   = OutInrBit + 1;
  localparam int unsigned OutOkBit    = OutTrkBit + 1;
  localparam int unsigned OutRvBit    = OutOkBit + 1;
  localparam int unsigned OutErrLsb   = OutRvBit + 1;
  localparam int unsigned OutUsedW    = OutErrLsb + PercentW;

  // Parameter defaults
  localparam int unsigned SampleCountDef    = 100;
  localparam int unsigned RecentWindowMsDef = 1000;
  localparam int unsigned MinStreakDef      = 2;

  // Fixed constants
  localparam logic [PercentW-1:0] FullPercent = PercentW'(100);
  localparam logic [StreakW-1:0]  StreakMax   = {StreakW{1'b1}};

  localparam logic [DistW-1:0] MinRangeRst = DistW'(20);
  localparam logic [DistW-1:0] MaxRangeRst = DistW'(4000);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_RANGE = 2'd0,
    REG_MAX_RANGE = 2'd1
  } cfg_reg_e;

  // One result item
  typedef struct packed {
    logic [DistW-1:0]    echo_mm;
    logic                in_range;
    logic                tracked;
    logic                counted_success;
    logic                rate_valid;
    logic [PercentW-1:0] error_percent;
  } eerm_result_t;

endpackage

// ===== src/echo_error_rate_monitor.sv =====
// ----------------------------------------------------------------------------
// echo_error_rate_monitor
// Scales echo readings to mm, checks the range and keeps a running error rate.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       echo_cm, now_ms
// m_axis    out        m_axis_tvalid/tready       echo_mm .. error_percent
// cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// An accepted item is registered in the input register, then passes
// through the tracking logic into the result register.
// Throughput is one item per cycle while m_axis does not stall; the
// tracking state updates as an item moves from the input register to the
// result register.
// Reset clears the tracking state and loads min 20 mm / max 4000 mm.
// A stall on m_axis holds the result; the input register still takes one
// more item, then s_axis_tready drops until the result is taken.
//
module echo_error_rate_monitor
  import eerm_pkg::*;
#(
  parameter int unsigned SAMPLE_COUNT     = SampleCountDef,
  parameter int unsigned RECENT_WINDOW_MS = RecentWindowMsDef,
  parameter int unsigned MIN_STREAK       = MinStreakDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [9:0] echo_cm, [41:10] now_ms, [47:42] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [13:0] echo_mm, [14] in_range, [15] tracked, [16] counted_success,
  // [17] rate_valid, [24:18] error_percent, [31:25] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // configuration write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DistW-1:0]    cfg_data_i
);

  logic               in_valid_q;
  logic [EchoW-1:0]   echo_q;
  logic [TimeW-1:0]   now_q;
  logic               out_valid_q;
  eerm_result_t       out_q;
  eerm_result_t       result;
  logic [DistW-1:0]   min_range_q, max_range_q;
  logic               advance;
  logic               in_accept;

  // Move an item into the result register when the slot is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= MinRangeRst;
      max_range_q <= MaxRangeRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_RANGE: min_range_q <= cfg_data_i;
        REG_MAX_RANGE: max_range_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      echo_q <= s_axis_tdata[InEchoLsb +: EchoW];
      now_q  <= s_axis_tdata[InTimeLsb +: TimeW];
    end
  end

  eerm_track #(
    .SAMPLE_COUNT     (SAMPLE_COUNT),
    .RECENT_WINDOW_MS (RECENT_WINDOW_MS),
    .MIN_STREAK       (MIN_STREAK)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .echo_cm_i   (echo_q),
    .now_ms_i    (now_q),
    .min_range_i (min_range_q),
    .max_range_i (max_range_q),
    .result_o    (result)
  );

  // Result register: hold while stalled, load on advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - OutUsedW){1'b0}},
                          out_q.error_percent,
                          out_q.rate_valid,
                          out_q.counted_success,
                          out_q.tracked,
                          out_q.in_range,
                          out_q.echo_mm};

endmodule

// ===== src/eerm_track.sv =====
// ----------------------------------------------------------------------------
// eerm_track
// Streak, warmup and success tracking for one reading per step.
// ----------------------------------------------------------------------------
module eerm_track
  import eerm_pkg::*;
#(
  parameter int unsigned SAMPLE_COUNT     = SampleCountDef,
  parameter int unsigned RECENT_WINDOW_MS = RecentWindowMsDef,
  parameter int unsigned MIN_STREAK       = MinStreakDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [EchoW-1:0]   echo_cm_i,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic [DistW-1:0]   min_range_i,
  input  logic [DistW-1:0]   max_range_i,
  output eerm_result_t       result_o
);

  localparam logic [CountW-1:0]  SampleCnt = CountW'(SAMPLE_COUNT);
  localparam logic [TimeW-1:0]   WindowMs  = TimeW'(RECENT_WINDOW_MS);
  localparam logic [StreakW-1:0] StreakMin = StreakW'(MIN_STREAK);

  logic [StreakW-1:0] streak_q, streak_d;
  logic [TimeW-1:0]   last_time_q, last_time_d;
  logic [CountW-1:0]  warm_q, warm_d;
  logic [CountW-1:0]  succ_q, succ_d;
  logic               done_q, done_d;

  logic [DistW-1:0] scaled_mm;
  logic             got, inr, track;
  logic [TimeW-1:0] elapsed;

  // cm * 10 as (cm * 8) + (cm * 2)
  assign scaled_mm = {1'b0, echo_cm_i, 3'b000} + {3'b000, echo_cm_i, 1'b0};
  assign got       = (echo_cm_i != '0);
  assign inr       = got && (scaled_mm >= min_range_i) && (scaled_mm <= max_range_i);
  assign elapsed   = now_ms_i - last_time_q;
  assign track     = inr || (!got && (streak_q >= StreakMin) && (elapsed < WindowMs));

  always_comb begin
    streak_d    = streak_q;
    last_time_d = last_time_q;
    warm_d      = warm_q;
    succ_d      = succ_q;
    done_d      = done_q;

    if (inr) begin
      if (streak_q != StreakMax) streak_d = streak_q + 1'b1;
      last_time_d = now_ms_i;
    end else if (got) begin
      if (streak_q != '0) streak_d = streak_q - 1'b1;
    end

    if (track) begin
      if (warm_q < SampleCnt) begin
        warm_d = warm_q + 1'b1;
        if (inr) succ_d = succ_q + 1'b1;
        if (warm_d >= SampleCnt) done_d = 1'b1;
      end else if (inr) begin
        if (succ_q < SampleCnt) succ_d = succ_q + 1'b1;
      end else if (succ_q != '0) begin
        succ_d = succ_q - 1'b1;
      end
    end
  end

  always_comb begin
    result_o.echo_mm         = got ? scaled_mm : '0;
    result_o.in_range        = inr;
    result_o.tracked         = track;
    result_o.counted_success = inr;
    result_o.rate_valid      = done_d;
    if (done_d && (succ_d < FullPercent)) begin
      result_o.error_percent = FullPercent - succ_d;
    end else begin
      result_o.error_percent = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      streak_q    <= '0;
      last_time_q <= '0;
      warm_q      <= '0;
      succ_q      <= '0;
      done_q      <= 1'b0;
    end else if (step_i) begin
      streak_q    <= streak_d;
      last_time_q <= last_time_d;
      warm_q      <= warm_d;
      succ_q      <= succ_d;
      done_q      <= done_d;
    end
  end

endmodule

// ===== src/eerm_checker.sv =====
// ----------------------------------------------------------------------------
// eerm_checker
// Port-level checks on the echo error rate monitor, bound to the top level.
// ----------------------------------------------------------------------------
module eerm_checker
  import eerm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic [DistW-1:0]    echo_mm;
  logic                inr, trk, ok, rv;
  logic [PercentW-1:0] err;

  assign echo_mm = m_axis_tdata[OutDistLsb +: DistW];
  assign inr     = m_axis_tdata[OutInrBit];
  assign trk     = m_axis_tdata[OutTrkBit];
  assign ok      = m_axis_tdata[OutOkBit];
  assign rv      = m_axis_tdata[OutRvBit];
  assign err     = m_axis_tdata[OutErrLsb +: PercentW];

  // An in-range echo is always a tracked success with a nonzero distance
  a_inr_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && inr) |-> (trk && ok && (echo_mm != '0)))
    else $error("in-range item not a tracked success");

  // A success only comes from an in-range echo
  a_ok_inr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ok) |-> inr)
    else $error("success without in-range echo");

  // Error rate reads zero before warmup ends and never exceeds one hundred
  a_err_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((rv || (err == '0)) && (err <= FullPercent)))
    else $error("error_percent out of bounds");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped while stalled");

endmodule

bind echo_error_rate_monitor eerm_checker u_eerm_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the echo error rate monitor.
// A short table of directed readings and register writes runs first. Seeded
// random phases follow, each with its own range setting and echo mix. Every
// result item is checked against a typed row or the in-bench model of the monitor.
// ----------------------------------------------------------------------------
module tb;
  import eerm_pkg::*;

  // Settle time for the block after the last result, before a register write.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned CycleLimit   = 400000;

  // Indexes past the two registers; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed table: a reading or a register write. The typed
  // result is used only where the row is marked as known.
  typedef struct packed {
    row_kind_e          kind;
    logic [EchoW-1:0]   echo_cm;
    logic [TimeW-1:0]   now_ms;
    logic [CfgIdxW-1:0] reg_idx;
    logic [DistW-1:0]   reg_val;
    logic               known;
    eerm_result_t       want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [DistW-1:0]    cfg_data_i    = '0;

  // Model state: range registers and tracking counters
  logic [DistW-1:0]    min_mm;
  logic [DistW-1:0]    max_mm;
  logic [StreakW-1:0]  streak;
  logic [TimeW-1:0]    last_valid_ms;
  logic [CountW-1:0]   warmup_cnt;
  logic [CountW-1:0]   success_cnt;
  logic                warmup_done;

  eerm_result_t        expected_results[$];
  dir_row_t            plan[$];
  int unsigned         mismatches  = 0;
  int unsigned         results_seen = 0;
  int unsigned         cycle_cnt   = 0;
  int unsigned         src_idle_pct = 0;
  int unsigned         snk_idle_pct = 0;
  logic [TimeW-1:0]    clock_ms;

  echo_error_rate_monitor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Model of the monitor
  // --------------------------------------------------------------------------

  task automatic model_reset();
    min_mm        = MinRangeRst;
    max_mm        = MaxRangeRst;
    streak        = '0;
    last_valid_ms = '0;
    warmup_cnt    = '0;
    success_cnt   = '0;
    warmup_done   = 1'b0;
  endtask

  // Advance the tracking state by one reading and return the result item.
  function automatic eerm_result_t track_reading(input logic [EchoW-1:0] cm,
                                                 input logic [TimeW-1:0] now);
    eerm_result_t     r;
    logic [DistW-1:0] scaled_mm;
    logic [TimeW-1:0] elapsed;
    logic             got;
    logic             inr;
    logic             trk;
    logic             ok;
    scaled_mm = DistW'(cm) * DistW'(10);
    got       = (cm != '0);
    inr       = got && (scaled_mm >= min_mm) && (scaled_mm <= max_mm);
    elapsed   = now - last_valid_ms;  // wraps modulo 2^32
    trk       = 1'b0;
    ok        = 1'b0;
    if (inr) begin
      if (streak != StreakMax) streak = streak + 1'b1;
      last_valid_ms = now;
      trk = 1'b1;
      ok  = 1'b1;
    end else if (got) begin
      if (streak != '0) streak = streak - 1'b1;
    end else if (streak >= MinStreakDef && elapsed < RecentWindowMsDef) begin
      // Lost echo right after a good streak: count it as a failure
      trk = 1'b1;
    end
    if (trk) begin
      if (warmup_cnt < SampleCountDef) begin
        warmup_cnt = warmup_cnt + 1'b1;
        if (ok) success_cnt = success_cnt + 1'b1;
        if (warmup_cnt >= SampleCountDef) warmup_done = 1'b1;
      end else if (ok) begin
        if (success_cnt < SampleCountDef) success_cnt = success_cnt + 1'b1;
      end else if (success_cnt != '0) begin
        success_cnt = success_cnt - 1'b1;
      end
    end
    r.echo_mm         = scaled_mm;
    r.in_range        = inr;
    r.tracked         = trk;
    r.counted_success = trk && ok;
    r.rate_valid      = warmup_done;
    r.error_percent   = (warmup_done && success_cnt < FullPercent) ?
                        FullPercent - success_cnt : '0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table construction
  // --------------------------------------------------------------------------

  task automatic add_item(input logic [EchoW-1:0] cm, input logic [TimeW-1:0] now);
    dir_row_t row;
    row         = '0;
    row.kind    = ROW_ITEM;
    row.echo_cm = cm;
    row.now_ms  = now;
    plan.push_back(row);
  endtask

  // Reading whose result can be typed in directly
  task automatic add_known(input logic [EchoW-1:0] cm, input logic [TimeW-1:0] now,
                           input logic [DistW-1:0] mm, input logic inr,
                           input logic trk, input logic ok, input logic rv,
                           input logic [PercentW-1:0] err);
    dir_row_t row;
    row         = '0;
    row.kind    = ROW_ITEM;
    row.echo_cm = cm;
    row.now_ms  = now;
    row.known   = 1'b1;
    row.want    = {mm, inr, trk, ok, rv, err};
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [DistW-1:0] val);
    dir_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Drop valid for a cycle at a time, at the sender's idle rate.
  task automatic maybe_gap();
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Offer one reading, wait for the handshake, then record what it must give.
  task automatic send_reading(input logic [EchoW-1:0] cm, input logic [TimeW-1:0] now,
                              input logic known, input eerm_result_t typed);
    logic [InDataW-1:0] data;
    eerm_result_t       predicted;
    data                         = '0;
    data[InEchoLsb +: EchoW]     = cm;
    data[InTimeLsb +: TimeW]     = now;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    // The model always advances; a typed row overrides only the expectation.
    predicted = track_reading(cm, now);
    expected_results.push_back(known ? typed : predicted);
  endtask

  // Stop offering input, let every result come back, then give the block
  // a few more cycles before anything is reconfigured or the run ends.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DistW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_MIN_RANGE) min_mm = val;
    else if (idx == REG_MAX_RANGE) max_mm = val;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
  endtask

  task automatic check_result(input logic [OutDataW-1:0] data);
    eerm_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected item, tdata", 32'(data), 32'd0);
      return;
    end
    want = expected_results.pop_front();
    if (data[OutDistLsb +: DistW] !== want.echo_mm)
      report_mismatch("echo_mm", 32'(data[OutDistLsb +: DistW]), 32'(want.echo_mm));
    if (data[OutInrBit] !== want.in_range)
      report_mismatch("in_range", 32'(data[OutInrBit]), 32'(want.in_range));
    if (data[OutTrkBit] !== want.tracked)
      report_mismatch("tracked", 32'(data[OutTrkBit]), 32'(want.tracked));
    if (data[OutOkBit] !== want.counted_success)
      report_mismatch("counted_success", 32'(data[OutOkBit]),
                      32'(want.counted_success));
    if (data[OutRvBit] !== want.rate_valid)
      report_mismatch("rate_valid", 32'(data[OutRvBit]), 32'(want.rate_valid));
    if (data[OutErrLsb +: PercentW] !== want.error_percent)
      report_mismatch("error_percent", 32'(data[OutErrLsb +: PercentW]),
                      32'(want.error_percent));
  endtask

  // Receiver: stall at the current idle rate, check each item taken.
  initial begin
    forever begin
      m_axis_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------

  // Echo in cm that lands inside the current range, if the range allows one.
  function automatic logic [EchoW-1:0] pick_in_range();
    int lo_cm;
    int hi_cm;
    lo_cm = (int'(min_mm) + 9) / 10;
    hi_cm = int'(max_mm) / 10;
    if (lo_cm < 1) lo_cm = 1;
    if (hi_cm > 1023) hi_cm = 1023;
    if (lo_cm > hi_cm) return EchoW'($urandom_range(1023, 1));
    return EchoW'($urandom_range(hi_cm, lo_cm));
  endfunction

  // Advance the timestamp: mostly small steps that keep lost echoes inside
  // the recent window, sometimes a step past it, rarely a jump anywhere.
  task automatic step_clock();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 5) clock_ms = $urandom();
    else if (r < 12) clock_ms = clock_ms + $urandom_range(3000, 800);
    else clock_ms = clock_ms + $urandom_range(400, 0);
  endtask

  // One random phase: set the range, then stream readings. Most are good
  // echoes or lost echoes, the rest are arbitrary 10-bit noise.
  task automatic run_phase(input logic [DistW-1:0] lo_mm, input logic [DistW-1:0] hi_mm,
                           input int unsigned n_items, input int unsigned zero_pct,
                           input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned      r;
    logic [EchoW-1:0] cm;
    drain();
    write_reg(REG_MIN_RANGE, lo_mm);
    @(posedge clk_i);
    write_reg(REG_MAX_RANGE, hi_mm);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      r = $urandom_range(99, 0);
      if (r < zero_pct) cm = '0;
      else if (r < zero_pct + (100 - zero_pct) * 3 / 4) cm = pick_in_range();
      else cm = EchoW'($urandom_range(1023, 0));
      step_clock();
      maybe_gap();
      send_reading(cm, clock_ms, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    model_reset();
    clock_ms = '0;

    // Reset values: 20 mm to 4000 mm, streak and counters clear
    add_known(10'd0,    32'd0,    14'd0,     1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
    add_known(10'd1023, 32'd5,    14'd10230, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
    add_known(10'd1,    32'd10,   14'd10,    1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
    // Both range edges are inclusive; two hits build a streak of two
    add_known(10'd2,    32'd1000, 14'd20,    1'b1, 1'b1, 1'b1, 1'b0, 7'd0);
    add_known(10'd400,  32'd1500, 14'd4000,  1'b1, 1'b1, 1'b1, 1'b0, 7'd0);
    // Lost echo just inside the recent window fails; one at the window does not
    add_known(10'd0,    32'd2499, 14'd0,     1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
    add_known(10'd0,    32'd2500, 14'd0,     1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
    // Just past the top edge: streak drops to one
    add_known(10'd401,  32'd2600, 14'd4010,  1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
    add_item(10'd0, 32'd2601);
    // Timestamp wrap: last hit near the top of the counter, then lost echoes
    add_item(10'd300, 32'hFFFF_FF00);
    add_item(10'd0,   32'h0000_0100);
    add_item(10'd0,   32'hFFFF_FFFF);
    // Inverted range: nothing is in range, streak drains to zero
    add_cfg(REG_MIN_RANGE, 14'd10230);
    add_cfg(REG_MAX_RANGE, 14'd0);
    add_item(10'd1023, 32'd40);
    add_item(10'd500,  32'd50);
    add_item(10'd0,    32'd60);
    // Widest range, then writes to the unused indexes must not disturb it
    add_cfg(REG_MIN_RANGE, 14'd0);
    add_cfg(REG_MAX_RANGE, 14'd10230);
    add_item(10'd1023, 32'd100);
    add_item(10'd1,    32'd200);
    add_cfg(RegSpare2, 14'h3FFF);
    add_cfg(RegSpare3, 14'h3FFF);
    add_item(10'd1,    32'd300);
    add_item(10'd0,    32'd301);
    add_item(10'd682,  32'h5555_5555);

    // Hold reset, then release it once for good
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part under the first idle pattern
    src_idle_pct = 20;
    snk_idle_pct = 71;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        maybe_gap();
        send_reading(plan[i].echo_cm, plan[i].now_ms, plan[i].known, plan[i].want);
      end
    end

    // Random part. The default range warms up the rate; the widest range with
    // mostly lost echoes drives the error rate up and the counter to its floor;
    // arbitrary ranges (often inverted) and a sane wide range follow.
    run_phase(14'd20, 14'd4000, 300, 25, 20, 71);
    run_phase(14'd0, 14'd10230, 250, 70, 71, 20);
    run_phase(DistW'($urandom_range(10230, 0)), DistW'($urandom_range(10230, 0)),
              150, 20, 0, 0);
    run_phase(DistW'($urandom_range(2000, 0)), DistW'($urandom_range(10230, 6000)),
              150, 35, 0, 0);

    // Wait out every outstanding result plus the pipeline, then judge
    drain();
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
